[design/lpsd_pkg.sv]
// ----------------------------------------------------------------------------
// lpsd_pkg: shared types and codes of the LED pixel serial driver
// Command and result payloads, the configuration set and the command codes.
// ----------------------------------------------------------------------------
package lpsd_pkg;

	// Command codes carried in the kind field
	localparam logic [2:0] KIND_NONE     = 3'd0;
	localparam logic [2:0] KIND_WRITE    = 3'd1;
	localparam logic [2:0] KIND_FILL     = 3'd2;
	localparam logic [2:0] KIND_SEND_BUF = 3'd3;
	localparam logic [2:0] KIND_SEND_ONE = 3'd4;
	localparam logic [2:0] KIND_LATCH    = 3'd5;

	// Configuration register indexes
	localparam logic [2:0] REG_PIXEL_COUNT = 3'd0;
	localparam logic [2:0] REG_ONE_HIGH    = 3'd1;
	localparam logic [2:0] REG_ONE_LOW     = 3'd2;
	localparam logic [2:0] REG_ZERO_HIGH   = 3'd3;
	localparam logic [2:0] REG_ZERO_LOW    = 3'd4;
	localparam logic [2:0] REG_LATCH       = 3'd5;

	// Configuration reset values
	localparam logic [10:0] PIXEL_COUNT_RST = 11'd0;
	localparam logic [7:0]  ONE_HIGH_RST    = 8'd14;
	localparam logic [7:0]  ONE_LOW_RST     = 8'd6;
	localparam logic [7:0]  ZERO_HIGH_RST   = 8'd6;
	localparam logic [7:0]  ZERO_LOW_RST    = 8'd8;
	localparam logic [15:0] LATCH_RST       = 16'd4160;

	// Bits in one pixel word
	localparam logic [4:0] PIXEL_BITS = 5'd24;

	typedef struct packed {
		logic [2:0] kind;
		logic [9:0] index;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} cmd_item_t;

	typedef struct packed {
		logic line_level;
		logic busy_res;
		logic accepted;
		logic rejected;
	} res_item_t;

	typedef struct packed {
		logic [10:0] pixel_count;
		logic [7:0]  one_high_ticks;
		logic [7:0]  one_low_ticks;
		logic [7:0]  zero_high_ticks;
		logic [7:0]  zero_low_ticks;
		logic [15:0] latch_ticks;
	} cfg_t;

endpackage

[design/led_pixel_serial_driver_core.sv]
// ----------------------------------------------------------------------------
// led_pixel_serial_driver_core: single-wire LED pixel line driver
// A tick is taken into the input register, processed by lpsd_engine and its
// result is offered from the output register. Throughput: one tick per cycle,
// set by the single pass through lpsd_engine, while res_stall does not hold.
// Reset clears control and configuration registers; the pixel store holds
// unknown data until written and needs no clearing pass.
// ----------------------------------------------------------------------------
module led_pixel_serial_driver_core
	import lpsd_pkg::*;
#(
	parameter int MAX_PIXELS = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_valid,
	output logic        cmd_stall,
	input  cmd_item_t   cmd_data,
	output logic        res_valid,
	input  logic        res_stall,
	output res_item_t   res_data,
	input  logic        cfg_write,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	cmd_item_t cmd_s1;
	logic      valid_s1;
	res_item_t res_q;
	logic      res_valid_q;
	cfg_t      cfg_q;
	res_item_t res_d;
	logic      advance;

	// Process the held tick when the output register is free or draining
	assign advance   = valid_s1 && (!res_valid_q || !res_stall);
	assign cmd_stall = valid_s1 && !advance;
	assign res_valid = res_valid_q;
	assign res_data  = res_q;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!cmd_stall) begin
			valid_s1 <= cmd_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_valid && !cmd_stall) begin
			cmd_s1 <= cmd_data;
		end
	end

	// Output register: load on advance, drop after the transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_d;
		end
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pixel_count     <= PIXEL_COUNT_RST;
			cfg_q.one_high_ticks  <= ONE_HIGH_RST;
			cfg_q.one_low_ticks   <= ONE_LOW_RST;
			cfg_q.zero_high_ticks <= ZERO_HIGH_RST;
			cfg_q.zero_low_ticks  <= ZERO_LOW_RST;
			cfg_q.latch_ticks     <= LATCH_RST;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_PIXEL_COUNT: cfg_q.pixel_count     <= cfg_data[10:0];
				REG_ONE_HIGH:    cfg_q.one_high_ticks  <= cfg_data[7:0];
				REG_ONE_LOW:     cfg_q.one_low_ticks   <= cfg_data[7:0];
				REG_ZERO_HIGH:   cfg_q.zero_high_ticks <= cfg_data[7:0];
				REG_ZERO_LOW:    cfg_q.zero_low_ticks  <= cfg_data[7:0];
				REG_LATCH:       cfg_q.latch_ticks     <= cfg_data;
				default: ;
			endcase
		end
	end

	lpsd_engine #(
		.MAX_PIXELS(MAX_PIXELS)
	) u_engine (
		.clk   (clk),
		.arst_n(arst_n),
		.step  (advance),
		.item  (cmd_s1),
		.cfg   (cfg_q),
		.res   (res_d)
	);

endmodule

[design/lpsd_engine.sv]
// ----------------------------------------------------------------------------
// lpsd_engine: per-tick command decode, pixel store and line waveform state
// Processes one tick per step: takes the command, advances fill, send or
// latch activity and forms the result for that tick.
// ----------------------------------------------------------------------------
module lpsd_engine
	import lpsd_pkg::*;
#(
	parameter int MAX_PIXELS = 1024
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      step,
	input  cmd_item_t item,
	input  cfg_t      cfg,
	output res_item_t res
);

	localparam int AW      = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
	localparam int LIM_CAP = (MAX_PIXELS > 2047) ? 2047 : MAX_PIXELS;

	typedef enum logic [2:0] {
		ACT_IDLE,
		ACT_FILL,
		ACT_SEND_BUF,
		ACT_SEND_ONE,
		ACT_LATCH
	} act_t;

	// Waveform and sequencing state
	act_t        act_q, act_d;
	logic [23:0] shift_q, shift_d;
	logic [4:0]  bits_q, bits_d;
	logic        high_q, high_d;
	logic [15:0] phase_q, phase_d;
	logic [10:0] ptr_q, ptr_d;
	logic [23:0] fill_q, fill_d;

	// Pixel store, its registered read port and a copy of entry zero
	logic [23:0] mem [MAX_PIXELS];
	logic [23:0] rd_data_q;
	logic [23:0] entry0_q;
	logic [15:0] rd_ext;
	logic        mem_we;
	logic [15:0] mem_wa_ext;
	logic [23:0] mem_wd;

	logic [10:0] limit;
	logic [23:0] colour;
	logic [15:0] oh_t, ol_t, zh_t, zl_t, lt_t;
	logic        is_cmd;
	logic        acc, rej, level, busy;

	// Entry limit: pixel_count saturated to the store depth
	assign limit = ({5'd0, cfg.pixel_count} < 16'(MAX_PIXELS)) ? cfg.pixel_count
	                                                            : 11'(LIM_CAP);

	assign colour = {item.green, item.red, item.blue};

	// Phase lengths, a zero register acting as one tick
	assign oh_t = (cfg.one_high_ticks == 8'd0) ? 16'd1 : {8'd0, cfg.one_high_ticks};
	assign ol_t = (cfg.one_low_ticks == 8'd0) ? 16'd1 : {8'd0, cfg.one_low_ticks};
	assign zh_t = (cfg.zero_high_ticks == 8'd0) ? 16'd1 : {8'd0, cfg.zero_high_ticks};
	assign zl_t = (cfg.zero_low_ticks == 8'd0) ? 16'd1 : {8'd0, cfg.zero_low_ticks};
	assign lt_t = (cfg.latch_ticks == 16'd0) ? 16'd1 : cfg.latch_ticks;

	assign is_cmd = (item.kind >= KIND_WRITE) && (item.kind <= KIND_LATCH);

	// Prefetch the entry after the one being sent
	assign rd_ext = {5'd0, ptr_q} + 16'd1;

	// Next state and result of this tick
	always_comb begin
		act_d   = act_q;
		shift_d = shift_q;
		bits_d  = bits_q;
		high_d  = high_q;
		phase_d = phase_q;
		ptr_d   = ptr_q;
		fill_d  = fill_q;
		acc     = 1'b0;
		rej     = 1'b0;
		level   = 1'b0;
		mem_we  = 1'b0;
		mem_wa_ext = {6'd0, item.index};
		mem_wd  = colour;

		// Take the command
		if (is_cmd && act_q != ACT_IDLE) begin
			rej = 1'b1;
		end else if (is_cmd) begin
			unique case (item.kind)
				KIND_WRITE: begin
					if ({1'b0, item.index} < limit) begin
						mem_we = 1'b1;
						acc    = 1'b1;
					end else begin
						rej = 1'b1;
					end
				end
				KIND_FILL: begin
					acc    = 1'b1;
					ptr_d  = 11'd0;
					fill_d = colour;
					act_d  = ACT_FILL;
				end
				KIND_SEND_BUF: begin
					acc   = 1'b1;
					ptr_d = 11'd0;
					act_d = ACT_SEND_BUF;
					if (limit != 11'd0) begin
						shift_d = entry0_q;
						bits_d  = PIXEL_BITS;
						high_d  = 1'b1;
						phase_d = entry0_q[23] ? oh_t : zh_t;
					end else begin
						act_d   = ACT_LATCH;
						high_d  = 1'b0;
						phase_d = lt_t;
					end
				end
				KIND_SEND_ONE: begin
					acc     = 1'b1;
					ptr_d   = 11'd0;
					act_d   = ACT_SEND_ONE;
					shift_d = colour;
					bits_d  = PIXEL_BITS;
					high_d  = 1'b1;
					phase_d = colour[23] ? oh_t : zh_t;
				end
				KIND_LATCH: begin
					acc     = 1'b1;
					ptr_d   = 11'd0;
					act_d   = ACT_LATCH;
					high_d  = 1'b0;
					phase_d = lt_t;
				end
				default: ;
			endcase
		end

		busy = (act_d != ACT_IDLE);

		// Run the activity for this tick
		unique case (act_d)
			ACT_FILL: begin
				if (ptr_d < limit) begin
					mem_we     = 1'b1;
					mem_wa_ext = {5'd0, ptr_d};
					mem_wd     = fill_d;
					ptr_d      = ptr_d + 11'd1;
				end
				if (ptr_d >= limit) begin
					act_d = ACT_IDLE;
				end
			end
			ACT_SEND_BUF, ACT_SEND_ONE: begin
				level = high_d;
				if (phase_d != 16'd0) begin
					phase_d = phase_d - 16'd1;
				end
				if (phase_d == 16'd0) begin
					if (high_d) begin
						high_d  = 1'b0;
						phase_d = shift_d[23] ? ol_t : zl_t;
					end else begin
						shift_d = {shift_d[22:0], 1'b0};
						if (bits_d != 5'd0) begin
							bits_d = bits_d - 5'd1;
						end
						if (bits_d != 5'd0) begin
							high_d  = 1'b1;
							phase_d = shift_d[23] ? oh_t : zh_t;
						end else if (act_d == ACT_SEND_BUF) begin
							ptr_d = ptr_d + 11'd1;
							if (ptr_d < limit) begin
								shift_d = rd_data_q;
								bits_d  = PIXEL_BITS;
								high_d  = 1'b1;
								phase_d = rd_data_q[23] ? oh_t : zh_t;
							end else begin
								act_d   = ACT_LATCH;
								high_d  = 1'b0;
								phase_d = lt_t;
							end
						end else begin
							act_d = ACT_IDLE;
						end
					end
				end
			end
			ACT_LATCH: begin
				if (phase_d != 16'd0) begin
					phase_d = phase_d - 16'd1;
				end
				if (phase_d == 16'd0) begin
					act_d = ACT_IDLE;
				end
			end
			default: ;
		endcase
	end

	assign res = '{line_level: level, busy_res: busy, accepted: acc, rejected: rej};

	// Hold state; advance only when the tick is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q   <= ACT_IDLE;
			shift_q <= '0;
			bits_q  <= '0;
			high_q  <= 1'b0;
			phase_q <= '0;
			ptr_q   <= '0;
			fill_q  <= '0;
		end else if (step) begin
			act_q   <= act_d;
			shift_q <= shift_d;
			bits_q  <= bits_d;
			high_q  <= high_d;
			phase_q <= phase_d;
			ptr_q   <= ptr_d;
			fill_q  <= fill_d;
		end
	end

	// Pixel store: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (mem_we && step) begin
			mem[mem_wa_ext[AW-1:0]] <= mem_wd;
		end
		rd_data_q <= mem[rd_ext[AW-1:0]];
	end

	// Mirror entry zero so a send can start in its own tick
	always_ff @(posedge clk) begin
		if (mem_we && step && mem_wa_ext == 16'd0) begin
			entry0_q <= mem_wd;
		end
	end

	a_bits_range: assert property (@(posedge clk) disable iff (!arst_n)
		bits_q <= PIXEL_BITS)
		else $error("bit counter beyond pixel width");

	a_high_only_sending: assert property (@(posedge clk) disable iff (!arst_n)
		high_q |-> (act_q == ACT_SEND_BUF || act_q == ACT_SEND_ONE))
		else $error("high phase outside a send");

	a_phase_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(act_q == ACT_SEND_BUF || act_q == ACT_SEND_ONE || act_q == ACT_LATCH)
			|-> phase_q != 16'd0)
		else $error("active phase with zero ticks left");

	a_ptr_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(act_q == ACT_FILL || act_q == ACT_SEND_BUF) |-> ptr_q <= limit)
		else $error("entry pointer past the limit");

endmodule
